FILE: sv/skt_pkg.sv
package skt_pkg;

    // Build size of the table and width of a stored key.
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;

    // Widths that follow from the build size, and the width of the capacity limit.
    localparam int POS_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int LIMIT_W = 7;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Port widths fixed by the interface.
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_OUT_W = 6;
    localparam int TOTAL_W  = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUCCESSOR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIRST     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STORE_ENABLED  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 4'd1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_op_t;

    // Compare flags that each cell registers against the search key.
    typedef struct packed {
        logic lt;
        logic le;
        logic hit;
    } cell_flags_t;

endpackage

FILE: sv/skt_cell.sv
module skt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::key_t       search_key,
    input  skt_pkg::cell_op_t   op,
    input  skt_pkg::key_t       left_key,
    input  logic                left_occ,
    input  logic                left_lt,
    input  logic                left_le,
    input  skt_pkg::key_t       right_key,
    input  logic                right_occ,
    output skt_pkg::key_t       slot_key,
    output logic                occ,
    output skt_pkg::cell_flags_t flags,
    output logic                ins_sel,
    output logic                succ_sel
);
    import skt_pkg::*;

    key_t        key_reg;
    key_t        key_next;
    logic        occ_reg;
    logic        occ_next;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    // Compare the stored key with the broadcast search key every cycle.
    always_comb
    begin
        flags_next.lt  = occ_reg && (key_reg < search_key);
        flags_next.le  = occ_reg && (key_reg <= search_key);
        flags_next.hit = occ_reg && (key_reg == search_key);
    end

    // This cell is the first one not below the key: the insert or match slot.
    assign ins_sel  = !flags_reg.lt && left_lt;
    // This cell is the first occupied one above the key.
    assign succ_sel = occ_reg && !flags_reg.le && left_le;

    // Cells below the boundary keep their entry; the rest shift by one place.
    always_comb
    begin
        key_next = key_reg;
        occ_next = occ_reg;
        if (op.shift_up && !flags_reg.lt)
        begin
            if (left_lt)
            begin
                key_next = search_key;
                occ_next = 1'b1;
            end
            else
            begin
                key_next = left_key;
                occ_next = left_occ;
            end
        end
        else if (op.shift_down && !flags_reg.lt)
        begin
            key_next = right_key;
            occ_next = right_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            flags_reg <= flags_next;
        end
    end

    // The key itself needs no reset: an unoccupied slot is never reported.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign slot_key = key_reg;
    assign occ      = occ_reg;
    assign flags    = flags_reg;

endmodule

FILE: sv/skt_pick.sv
module skt_pick (
    input  logic [skt_pkg::CAPACITY-1:0] ins_sel,
    input  logic [skt_pkg::CAPACITY-1:0] succ_sel,
    input  skt_pkg::key_t                slot_key [skt_pkg::CAPACITY],
    output skt_pkg::pos_t                ins_pos,
    output skt_pkg::pos_t                succ_pos,
    output logic                         succ_found,
    output skt_pkg::key_t                succ_key
);
    import skt_pkg::*;

    // Encode the one-hot boundary flags and select the successor key.
    always_comb
    begin
        ins_pos  = '0;
        succ_pos = '0;
        succ_key = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            ins_pos  = ins_pos  | (ins_sel[j]  ? POS_W'(j) : '0);
            succ_pos = succ_pos | (succ_sel[j] ? POS_W'(j) : '0);
            succ_key = succ_key | (slot_key[j] & {KEY_BITS{succ_sel[j]}});
        end
    end

    assign succ_found = |succ_sel;

endmodule

FILE: sv/sorted_key_table.sv
// Ordered key table built as a row of compare-and-shift cells.
// Each request passes through a compare state and then an execute state before its result is valid.
// A new request is taken in the execute state, once the result register can accept the result;
// the compare state is needed for the registered compare flags that each cell feeds to the encoder.
// Reset empties the table, enables the store and sets the capacity limit to 64.
module sorted_key_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [skt_pkg::CMD_W-1:0]       cmd,
    input  logic [skt_pkg::KEY_W-1:0]       key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [skt_pkg::STATUS_W-1:0]    status,
    output logic [skt_pkg::POS_OUT_W-1:0]   position,
    output logic [skt_pkg::KEY_W-1:0]       key_out,
    output logic [skt_pkg::TOTAL_W-1:0]     entry_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [skt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import skt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXE  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CMD_W-1:0]   cmd_reg;
    key_t               key_reg;
    cnt_t               count_reg;
    cnt_t               count_next;
    logic               enabled_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    pos_t                 pos_reg;
    pos_t                 pos_next;
    key_t                 kout_reg;
    key_t                 kout_next;
    cnt_t                 total_reg;

    logic     go;
    logic     in_acc;
    cell_op_t op;

    key_t                slot_key [CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] le_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] ins_sel;
    logic [CAPACITY-1:0] succ_sel;
    cell_flags_t         flags [CAPACITY];

    pos_t ins_pos;
    pos_t succ_pos;
    logic succ_found;
    key_t succ_key;
    logic hit;
    logic full;

    // Handshakes.
    assign go        = (state_reg == S_EXE) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || go;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Row of cells; the ends see an empty neighbor, and the first cell sees its left side as below the key.
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        key_t l_key;
        logic l_occ;
        logic l_lt;
        logic l_le;
        key_t r_key;
        logic r_occ;

        if (j == 0)
        begin : g_first
            assign l_key = '0;
            assign l_occ = 1'b0;
            assign l_lt  = 1'b1;
            assign l_le  = 1'b1;
        end
        else
        begin : g_mid
            assign l_key = slot_key[j-1];
            assign l_occ = occ[j-1];
            assign l_lt  = lt_vec[j-1];
            assign l_le  = le_vec[j-1];
        end

        if (j == CAPACITY - 1)
        begin : g_last
            assign r_key = '0;
            assign r_occ = 1'b0;
        end
        else
        begin : g_inner
            assign r_key = slot_key[j+1];
            assign r_occ = occ[j+1];
        end

        skt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .search_key (key_reg),
            .op         (op),
            .left_key   (l_key),
            .left_occ   (l_occ),
            .left_lt    (l_lt),
            .left_le    (l_le),
            .right_key  (r_key),
            .right_occ  (r_occ),
            .slot_key   (slot_key[j]),
            .occ        (occ[j]),
            .flags      (flags[j]),
            .ins_sel    (ins_sel[j]),
            .succ_sel   (succ_sel[j])
        );

        assign lt_vec[j]  = flags[j].lt;
        assign le_vec[j]  = flags[j].le;
        assign hit_vec[j] = flags[j].hit;
    end

    skt_pick u_pick (
        .ins_sel    (ins_sel),
        .succ_sel   (succ_sel),
        .slot_key   (slot_key),
        .ins_pos    (ins_pos),
        .succ_pos   (succ_pos),
        .succ_found (succ_found),
        .succ_key   (succ_key)
    );

    assign hit  = |hit_vec;
    assign full = (count_reg >= cnt_t'(CAPACITY))
               || (CMP_W'(count_reg) >= CMP_W'(limit_reg));

    // Decide the result and the shift for the request in the execute cycle.
    always_comb
    begin
        status_next = ST_REFUSED;
        pos_next    = '0;
        kout_next   = '0;
        count_next  = count_reg;
        op          = '0;
        if (!enabled_reg || (limit_reg == '0))
        begin
            count_next = '0;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_LOOKUP:
                begin
                    if (hit)
                    begin
                        status_next = ST_DONE;
                        pos_next    = ins_pos;
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                CMD_INSERT:
                begin
                    if (hit)
                    begin
                        status_next = ST_DONE;
                        pos_next    = ins_pos;
                    end
                    else if (!full)
                    begin
                        status_next = ST_INSERTED;
                        pos_next    = ins_pos;
                        op.shift_up = go;
                        count_next  = count_reg + cnt_t'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        status_next   = ST_DONE;
                        pos_next      = ins_pos;
                        op.shift_down = go;
                        count_next    = count_reg - cnt_t'(1);
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                CMD_SUCCESSOR:
                begin
                    if (succ_found)
                    begin
                        status_next = ST_DONE;
                        pos_next    = succ_pos;
                        kout_next   = succ_key;
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                CMD_FIRST:
                begin
                    if (occ[0])
                    begin
                        status_next = ST_DONE;
                        kout_next   = slot_key[0];
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                default:
                begin
                    status_next = ST_REFUSED;
                end
            endcase
        end
    end

    // Sequencer: compare cycle, then execute cycle.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXE;
            end
            S_EXE:
            begin
                if (go)
                begin
                    state_next = in_acc ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers, configuration and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            enabled_reg   <= 1'b1;
            limit_reg     <= LIMIT_W'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_STORE_ENABLED)
                begin
                    enabled_reg <= cfg_data[0];
                end
                else if (cfg_index == REG_CAPACITY_LIMIT)
                begin
                    limit_reg <= cfg_data[LIMIT_W-1:0];
                end
            end
            if (go)
            begin
                count_reg     <= (op.shift_up || op.shift_down) ? count_next : count_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch and result register.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= cmd;
            key_reg <= key[KEY_BITS-1:0];
        end
        if (go)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            kout_reg   <= kout_next;
            total_reg  <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = POS_OUT_W'(pos_reg);
    assign key_out     = KEY_W'(kout_reg);
    assign entry_total = TOTAL_W'(total_reg);

endmodule
